// File: src/dbpfs_pkg.sv
// ----------------------------------------------------------------------------
// dbpfs_pkg: shared types and constants for the fan speed controller
// Register indexes, event kinds, reset values and the bundles passed
// between the configuration, debounce and control modules.
// ----------------------------------------------------------------------------
package dbpfs_pkg;

  localparam int unsigned ValW   = 8;   // width of the configuration registers and counters
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSpeedStep   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAdjInterval = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDebMax      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDebMin      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPressThr    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReleaseThr  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFullOn      = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOffValue    = 3'd7;

  // event kinds
  typedef enum logic [ModeW-1:0] {
    ModePoll    = 2'd0,
    ModeTick    = 2'd1,
    ModeCompare = 2'd2,
    ModeUnused  = 2'd3
  } mode_e;

  // reset values
  localparam logic [ValW-1:0] RstSpeedStep   = 8'd4;
  localparam logic [ValW-1:0] RstAdjInterval = 8'd50;
  localparam logic [ValW-1:0] RstDebMax      = 8'd2;
  localparam logic [ValW-1:0] RstDebMin      = 8'd1;
  localparam logic [ValW-1:0] RstPressThr    = 8'd2;
  localparam logic [ValW-1:0] RstReleaseThr  = 8'd1;
  localparam logic [ValW-1:0] RstFullOn      = 8'h01;
  localparam logic [ValW-1:0] RstOffValue    = 8'hff;
  localparam logic [ValW-1:0] RstCount       = 8'd1;
  localparam logic [ValW-1:0] RstOnCompare   = 8'h01;
  localparam logic [ValW-1:0] RstCompare     = 8'h01;
  localparam logic [ValW-1:0] TickMax        = 8'hff;
  localparam int unsigned     LedShift       = 5;   // speed / 32 picks the LED

  typedef struct packed {
    logic [ValW-1:0] speed_step;
    logic [ValW-1:0] adjust_interval;
    logic [ValW-1:0] debounce_max;
    logic [ValW-1:0] debounce_min;
    logic [ValW-1:0] press_threshold;
    logic [ValW-1:0] release_threshold;
    logic [ValW-1:0] full_on_value;
    logic [ValW-1:0] off_value;
  } cfg_t;

  typedef struct packed {
    logic            fan_drive;
    logic            pwm_enabled;
    logic [ValW-1:0] next_compare;
    logic [ValW-1:0] speed_setting;
  } res_t;

endpackage

// File: src/debounced_button_pwm_fan_speed.sv
// ----------------------------------------------------------------------------
// debounced_button_pwm_fan_speed: PWM fan speed controller, two buttons
// Channel  Dir  Word                                   Accepted when
// s_axis   in   tuser mode, tdata up_pin/down_pin      tvalid && tready
// m_axis   out  fan/pwm/compare/speed/led              tvalid && tready
// cfg      in   index + byte                           cfg_we_i
//
// One word per cycle sustained while m_axis_tready holds; a taken word fills
// the input register, then the result register after one short pass of
// compares and 9-bit adds. Reset puts the valid flags and state registers
// at their reset values, not the word or result data; no clearing pass.
// The input register takes a new word while a result waits, so a stalled
// output costs one stage before s_axis_tready drops.
// ----------------------------------------------------------------------------
module debounced_button_pwm_fan_speed (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [dbpfs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dbpfs_pkg::ValW-1:0]       cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dbpfs_pkg::InDataW-1:0]    s_axis_tdata,  // [0] up_pin, [1] down_pin
  input  logic [dbpfs_pkg::ModeW-1:0]      s_axis_tuser,  // [1:0] mode
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] fan_drive, [1] pwm_enabled, [9:2] next_compare,
  // [17:10] speed_setting, [25:18] led_pattern
  output logic [dbpfs_pkg::OutDataW-1:0]   m_axis_tdata
);
  import dbpfs_pkg::*;

  cfg_t             cfg;
  res_t             res;
  logic             in_vld_q;
  logic [ModeW-1:0] mode_q;
  logic             up_q, down_q;
  logic             out_vld_q;
  res_t             res_q;
  logic             fire;
  logic             poll;
  logic             up_pressed, down_pressed;
  logic [ValW-1:0]  led;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign poll          = fire && (mode_e'(mode_q) == ModePoll);
  assign s_axis_tready = !in_vld_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mode_q <= s_axis_tuser;
      up_q   <= s_axis_tdata[0];
      down_q <= s_axis_tdata[1];
    end
  end

  dbpfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dbpfs_debounce u_deb_up (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .poll_i    (poll),
    .pin_i     (up_q),
    .cfg_i     (cfg),
    .pressed_o (up_pressed)
  );

  dbpfs_debounce u_deb_down (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .poll_i    (poll),
    .pin_i     (down_q),
    .cfg_i     (cfg),
    .pressed_o (down_pressed)
  );

  dbpfs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .mode_i         (mode_q),
    .up_pressed_i   (up_pressed),
    .down_pressed_i (down_pressed),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res;
  end

  // active-low one-hot LED from the top three speed bits
  assign led = ~(ValW'(1) << res_q.speed_setting[ValW-1:LedShift]);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, led, res_q.speed_setting, res_q.next_compare,
                          res_q.pwm_enabled, res_q.fan_drive};

endmodule

// File: src/dbpfs_cfg.sv
// ----------------------------------------------------------------------------
// dbpfs_cfg: configuration register file
// Eight byte-wide registers, written through a plain write port.
// ----------------------------------------------------------------------------
module dbpfs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dbpfs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dbpfs_pkg::ValW-1:0]       cfg_wdata_i,
  output dbpfs_pkg::cfg_t                  cfg_o
);
  import dbpfs_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSpeedStep:   cfg_d.speed_step        = cfg_wdata_i;
        RegAdjInterval: cfg_d.adjust_interval   = cfg_wdata_i;
        RegDebMax:      cfg_d.debounce_max      = cfg_wdata_i;
        RegDebMin:      cfg_d.debounce_min      = cfg_wdata_i;
        RegPressThr:    cfg_d.press_threshold   = cfg_wdata_i;
        RegReleaseThr:  cfg_d.release_threshold = cfg_wdata_i;
        RegFullOn:      cfg_d.full_on_value     = cfg_wdata_i;
        RegOffValue:    cfg_d.off_value         = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_step        <= RstSpeedStep;
      cfg_q.adjust_interval   <= RstAdjInterval;
      cfg_q.debounce_max      <= RstDebMax;
      cfg_q.debounce_min      <= RstDebMin;
      cfg_q.press_threshold   <= RstPressThr;
      cfg_q.release_threshold <= RstReleaseThr;
      cfg_q.full_on_value     <= RstFullOn;
      cfg_q.off_value         <= RstOffValue;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/dbpfs_debounce.sv
// ----------------------------------------------------------------------------
// dbpfs_debounce: one button debouncer
// Saturating counter between floor and ceiling, pressed flag with hysteresis.
// The updated pressed flag is also given combinationally for the same poll.
// ----------------------------------------------------------------------------
module dbpfs_debounce (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            poll_i,      // a poll word is processed this cycle
  input  logic            pin_i,       // raw level, low means pressed
  input  dbpfs_pkg::cfg_t cfg_i,
  output logic            pressed_o    // pressed flag after this poll
);
  import dbpfs_pkg::*;

  logic [ValW-1:0] count_q, count_d;
  logic            pressed_q, pressed_d;
  logic [ValW:0]   count_inc;

  // counter step: up toward the ceiling, down toward the floor
  always_comb begin
    count_inc = {1'b0, count_q} + {{ValW{1'b0}}, 1'b1};
    if (!pin_i) begin
      count_d = (count_inc > {1'b0, cfg_i.debounce_max}) ? cfg_i.debounce_max
                                                         : count_inc[ValW-1:0];
    end else begin
      count_d = (count_q > cfg_i.debounce_min) ? count_q - ValW'(1) : cfg_i.debounce_min;
    end
  end

  // hysteresis, press test first
  always_comb begin
    if (count_d >= cfg_i.press_threshold) begin
      pressed_d = 1'b1;
    end else if (count_d <= cfg_i.release_threshold) begin
      pressed_d = 1'b0;
    end else begin
      pressed_d = pressed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= RstCount;
      pressed_q <= 1'b0;
    end else if (poll_i) begin
      count_q   <= count_d;
      pressed_q <= pressed_d;
    end
  end

  assign pressed_o = poll_i ? pressed_d : pressed_q;

endmodule

// File: src/dbpfs_ctrl.sv
// ----------------------------------------------------------------------------
// dbpfs_ctrl: tick counter, speed adjustment and PWM toggle
// Holds the controller state and gives its value after the current word.
// ----------------------------------------------------------------------------
module dbpfs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,     // a word is processed
  input  logic [dbpfs_pkg::ModeW-1:0]   mode_i,
  input  logic                          up_pressed_i,
  input  logic                          down_pressed_i,
  input  dbpfs_pkg::cfg_t               cfg_i,
  output dbpfs_pkg::res_t               res_o
);
  import dbpfs_pkg::*;

  logic [ValW-1:0] tick_q, tick_d;
  logic [ValW-1:0] on_cmp_q, on_cmp_d;
  logic [ValW-1:0] cmp_q, cmp_d;
  logic            fan_q, fan_d;
  logic            pwm_q, pwm_d;
  logic [ValW:0]   up_sum;
  logic [ValW:0]   down_lim;
  logic            adjust;

  // adjustment arithmetic
  assign up_sum   = {1'b0, on_cmp_q} + {1'b0, cfg_i.speed_step};
  assign down_lim = {1'b0, cfg_i.speed_step} + {1'b0, cfg_i.full_on_value};
  assign adjust   = (tick_q >= cfg_i.adjust_interval);

  // next state per event kind
  always_comb begin
    tick_d   = tick_q;
    on_cmp_d = on_cmp_q;
    cmp_d    = cmp_q;
    fan_d    = fan_q;
    pwm_d    = pwm_q;
    case (mode_e'(mode_i))
      ModePoll: begin
        if (adjust) begin
          tick_d = '0;
          if (up_pressed_i) begin
            on_cmp_d = (up_sum < {1'b0, cfg_i.off_value}) ? up_sum[ValW-1:0]
                                                           : cfg_i.off_value;
          end else if (down_pressed_i) begin
            // on - step > full  <=>  on > step + full
            on_cmp_d = ({1'b0, on_cmp_q} > down_lim) ? on_cmp_q - cfg_i.speed_step
                                                     : cfg_i.full_on_value;
          end
        end
      end
      ModeTick: begin
        if (tick_q != TickMax) tick_d = tick_q + ValW'(1);
      end
      ModeCompare: begin
        if (on_cmp_q == cfg_i.off_value) begin
          pwm_d = 1'b0;
          fan_d = 1'b0;
        end else begin
          fan_d = !fan_q;
          pwm_d = 1'b1;
          cmp_d = fan_d ? cfg_i.off_value : on_cmp_q;
        end
      end
      default: begin
        tick_d = tick_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      on_cmp_q <= RstOnCompare;
      cmp_q    <= RstCompare;
      fan_q    <= 1'b0;
      pwm_q    <= 1'b1;
    end else if (fire_i) begin
      tick_q   <= tick_d;
      on_cmp_q <= on_cmp_d;
      cmp_q    <= cmp_d;
      fan_q    <= fan_d;
      pwm_q    <= pwm_d;
    end
  end

  assign res_o.fan_drive     = fan_d;
  assign res_o.pwm_enabled   = pwm_d;
  assign res_o.next_compare  = cmp_d;
  assign res_o.speed_setting = on_cmp_d;

endmodule

// File: src/dbpfs_checker.sv
// ----------------------------------------------------------------------------
// dbpfs_checker: port-level checks for the fan speed controller
// Output stall behavior, LED coding, fan/PWM consistency and reset state.
// ----------------------------------------------------------------------------
module dbpfs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dbpfs_pkg::OutDataW-1:0]   m_axis_tdata
);
  import dbpfs_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // LED is the active-low one-hot of speed / 32, padding is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[25:18] == ~(8'd1 << m_axis_tdata[17:15]))
                      && (m_axis_tdata[31:26] == 6'd0))
    else $error("LED pattern does not match speed");

  // fan never powered with PWM disabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("fan driven while PWM off");

  // no result right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind debounced_button_pwm_fan_speed dbpfs_checker u_dbpfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
